// File: hw/rtl/tire_sensor_alarm_table_assert.svh
// ----------------------------------------------------------------------------
// Tire sensor alarm table assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TIRE_SENSOR_ALARM_TABLE_ASSERT_SVH
`define TIRE_SENSOR_ALARM_TABLE_ASSERT_SVH

// antecedent implies consequent, same cycle (consequent may carry a delay)
`define TSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// plain invariant, checked at every edge outside reset
`define TSA_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

`endif

// File: hw/rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// Tire sensor alarm table package
// Operation, status and register codes, reset values and alarm helpers.
// ----------------------------------------------------------------------------
package tsa_pkg;

   localparam int PresW  = 14;
   localparam int TempW  = 12;
   localparam int IdentW = 32;
   localparam int TicksW = 32;
   localparam int OpW    = 3;
   localparam int SlotW  = 3;
   localparam int CsrAddrW = 5;
   localparam int CsrDataW = 32;

   typedef enum logic [OpW-1:0] {
      OP_REGISTER   = 3'd0,
      OP_UNREGISTER = 3'd1,
      OP_UPDATE     = 3'd2,
      OP_GET        = 3'd3,
      OP_TICK       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_INVALID     = 2'd1,
      STATUS_NOT_ALLOWED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_NORMAL_FRONT   = 3'd0,
      CSR_NORMAL_REAR    = 3'd1,
      CSR_CAUTION_DEV    = 3'd2,
      CSR_CRITICAL_DEV   = 3'd3,
      CSR_TEMP_CAUTION   = 3'd4,
      CSR_TEMP_CRITICAL  = 3'd5,
      CSR_VALID_TICKS    = 3'd6
   } csr_index_type;

   localparam logic [PresW-1:0]        NormalFrontReset = 14'd2300;
   localparam logic [PresW-1:0]        NormalRearReset  = 14'd2300;
   localparam logic [PresW-1:0]        CautionDevReset  = 14'd200;
   localparam logic [PresW-1:0]        CriticalDevReset = 14'd400;
   localparam logic signed [TempW-1:0] TempLimitReset   = 12'sd0;
   localparam logic [TicksW-1:0]       ValidTicksReset  = 32'd0;

   // pressure outside nominal +/- deviation; widened one bit so sums never wrap
   function automatic logic band_alarm(input logic [PresW-1:0] pres,
                                       input logic [PresW-1:0] nominal,
                                       input logic [PresW-1:0] dev);
      logic [PresW:0] p_plus_d;
      logic [PresW:0] n_plus_d;
      p_plus_d = {1'b0, pres} + {1'b0, dev};
      n_plus_d = {1'b0, nominal} + {1'b0, dev};
      return (p_plus_d < {1'b0, nominal}) || ({1'b0, pres} > n_plus_d);
   endfunction

   // limit only counts when positive
   function automatic logic temp_alarm(input logic signed [TempW-1:0] temp,
                                       input logic signed [TempW-1:0] limit);
      return (limit > 12'sd0) && (temp > limit);
   endfunction

endpackage

// File: hw/rtl/tire_sensor_alarm_table.sv
// ----------------------------------------------------------------------------
// Tire sensor alarm table
// Per-slot sensor id, reading, validity timeout and pressure/temp alarms.
// ----------------------------------------------------------------------------
//
//   channel   ports                          handshake
//   -------   ----------------------------   ------------------------------
//   request   req_op/ident/slot/pres/temp    start & !busy
//   response  rsp_status ... rsp_critical_any rsp_valid strobe, one cycle
//   csr       psel/penable/pwrite/paddr/...  APB write, pready tied high
//
// One word per cycle in, one response word per request word.
// The request word is registered, then one pass of compare/update logic writes
// the slot state and the response register in the same cycle.
// busy is a register that reset sets and that clears once reset is released;
// otherwise a word is taken every cycle.
// Reset is synchronous and restores the table and csr defaults.
// The response side cannot stall; rsp_valid pulses once per word.
// ----------------------------------------------------------------------------
module tire_sensor_alarm_table #(
   parameter int NUM_TIRES = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request
   input  logic                                   start,
   output logic                                   busy,
   input  logic [tsa_pkg::OpW-1:0]                req_op,
   input  logic [tsa_pkg::IdentW-1:0]             req_sensor_ident,
   input  logic [tsa_pkg::SlotW-1:0]              req_slot,
   input  logic [tsa_pkg::PresW-1:0]              req_pressure_in,
   input  logic signed [tsa_pkg::TempW-1:0]       req_temperature_in,
   // response
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic                                   rsp_data_valid,
   output logic                                   rsp_tire_alarm,
   output logic [tsa_pkg::PresW-1:0]              rsp_pressure_out,
   output logic signed [tsa_pkg::TempW-1:0]       rsp_temperature_out,
   output logic                                   rsp_critical_any,
   // csr
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [tsa_pkg::CsrAddrW-1:0]           paddr,
   input  logic [tsa_pkg::CsrDataW-1:0]           pwdata,
   output logic [tsa_pkg::CsrDataW-1:0]           prdata,
   output logic                                   pready
);

   localparam int PresW  = tsa_pkg::PresW;
   localparam int TempW  = tsa_pkg::TempW;
   localparam int IdentW = tsa_pkg::IdentW;
   localparam int TicksW = tsa_pkg::TicksW;

   // ---------------- csr ----------------
   logic [PresW-1:0]        normal_front_ff, normal_rear_ff;
   logic [PresW-1:0]        caution_dev_ff, critical_dev_ff;
   logic signed [TempW-1:0] temp_caution_ff, temp_critical_ff;
   logic [TicksW-1:0]       valid_ticks_ff;
   logic                    csr_wr;
   tsa_pkg::csr_index_type  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = tsa_pkg::csr_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_front_ff  <= tsa_pkg::NormalFrontReset;
         normal_rear_ff   <= tsa_pkg::NormalRearReset;
         caution_dev_ff   <= tsa_pkg::CautionDevReset;
         critical_dev_ff  <= tsa_pkg::CriticalDevReset;
         temp_caution_ff  <= tsa_pkg::TempLimitReset;
         temp_critical_ff <= tsa_pkg::TempLimitReset;
         valid_ticks_ff   <= tsa_pkg::ValidTicksReset;
      end else if (csr_wr) begin
         unique case (csr_idx)
            tsa_pkg::CSR_NORMAL_FRONT:  normal_front_ff  <= pwdata[PresW-1:0];
            tsa_pkg::CSR_NORMAL_REAR:   normal_rear_ff   <= pwdata[PresW-1:0];
            tsa_pkg::CSR_CAUTION_DEV:   caution_dev_ff   <= pwdata[PresW-1:0];
            tsa_pkg::CSR_CRITICAL_DEV:  critical_dev_ff  <= pwdata[PresW-1:0];
            tsa_pkg::CSR_TEMP_CAUTION:  temp_caution_ff  <= pwdata[TempW-1:0];
            tsa_pkg::CSR_TEMP_CRITICAL: temp_critical_ff <= pwdata[TempW-1:0];
            tsa_pkg::CSR_VALID_TICKS:   valid_ticks_ff   <= pwdata[TicksW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tsa_pkg::CSR_NORMAL_FRONT:  prdata = {{(32-PresW){1'b0}}, normal_front_ff};
         tsa_pkg::CSR_NORMAL_REAR:   prdata = {{(32-PresW){1'b0}}, normal_rear_ff};
         tsa_pkg::CSR_CAUTION_DEV:   prdata = {{(32-PresW){1'b0}}, caution_dev_ff};
         tsa_pkg::CSR_CRITICAL_DEV:  prdata = {{(32-PresW){1'b0}}, critical_dev_ff};
         tsa_pkg::CSR_TEMP_CAUTION:  prdata = {{(32-TempW){1'b0}}, temp_caution_ff};
         tsa_pkg::CSR_TEMP_CRITICAL: prdata = {{(32-TempW){1'b0}}, temp_critical_ff};
         tsa_pkg::CSR_VALID_TICKS:   prdata = valid_ticks_ff;
         default:                    prdata = '0;
      endcase
   end

   // ---------------- request register ----------------
   logic                       busy_ff;
   logic                       in_valid_ff;
   tsa_pkg::op_type            in_op_ff;
   logic [IdentW-1:0]          in_ident_ff;
   logic [tsa_pkg::SlotW-1:0]  in_slot_ff;
   logic [PresW-1:0]           in_pres_ff;
   logic signed [TempW-1:0]    in_temp_ff;
   logic                       accept;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff    <= tsa_pkg::op_type'(req_op);
         in_ident_ff <= req_sensor_ident;
         in_slot_ff  <= req_slot;
         in_pres_ff  <= req_pressure_in;
         in_temp_ff  <= req_temperature_in;
      end
   end

   // ---------------- slot table ----------------
   logic [IdentW-1:0]       ident_ff [NUM_TIRES];
   logic [IdentW-1:0]       ident_in [NUM_TIRES];
   logic [PresW-1:0]        pres_ff  [NUM_TIRES];
   logic [PresW-1:0]        pres_in  [NUM_TIRES];
   logic signed [TempW-1:0] temp_ff  [NUM_TIRES];
   logic signed [TempW-1:0] temp_in  [NUM_TIRES];
   logic [TicksW-1:0]       count_ff [NUM_TIRES];
   logic [TicksW-1:0]       count_in [NUM_TIRES];
   logic [NUM_TIRES-1:0]    valid_ff, valid_in;
   logic [NUM_TIRES-1:0]    run_ff, run_in;

   logic [NUM_TIRES-1:0]    id_match, id_first, slot_sel;
   logic [NUM_TIRES-1:0]    caution, critical;
   logic                    id_zero, id_hit, slot_ok, found;
   logic [TicksW-1:0]       count_dec;
   logic [PresW-1:0]        nominal;

   // response next values
   tsa_pkg::status_type     status_in;
   logic                    data_valid_in, tire_alarm_in, master_in;
   logic [PresW-1:0]        pres_out_in;
   logic signed [TempW-1:0] temp_out_in;

   always_comb begin
      id_zero = (in_ident_ff == '0);
      slot_ok = ({1'b0, in_slot_ff} < 4'(NUM_TIRES));
      found   = 1'b0;
      for (int i = 0; i < NUM_TIRES; i++) begin
         id_match[i] = (ident_ff[i] == in_ident_ff);
         // idents are unique, but keep lowest-slot priority anyway
         id_first[i] = id_match[i] && !found;
         found       = found || id_match[i];
         slot_sel[i] = (in_slot_ff == tsa_pkg::SlotW'(i));
      end
      id_hit = found;

      // next state
      for (int i = 0; i < NUM_TIRES; i++) begin
         ident_in[i] = ident_ff[i];
         pres_in[i]  = pres_ff[i];
         temp_in[i]  = temp_ff[i];
         count_in[i] = count_ff[i];
         valid_in[i] = valid_ff[i];
         run_in[i]   = run_ff[i];
         count_dec   = count_ff[i] - 1'b1;
         if (in_valid_ff) begin
            case (in_op_ff)
               tsa_pkg::OP_REGISTER: begin
                  if (!id_zero && slot_ok && !id_hit && slot_sel[i]) begin
                     ident_in[i] = in_ident_ff;
                     valid_in[i] = 1'b0;
                     run_in[i]   = 1'b0;
                     count_in[i] = '0;
                  end
               end
               tsa_pkg::OP_UNREGISTER: begin
                  if (!id_zero && id_first[i]) begin
                     ident_in[i] = '0;
                     valid_in[i] = 1'b0;
                     run_in[i]   = 1'b0;
                     count_in[i] = '0;
                  end
               end
               tsa_pkg::OP_UPDATE: begin
                  if (!id_zero && id_first[i]) begin
                     pres_in[i]  = in_pres_ff;
                     temp_in[i]  = in_temp_ff;
                     valid_in[i] = 1'b1;
                     run_in[i]   = (valid_ticks_ff != '0);
                     count_in[i] = valid_ticks_ff;   // zero when timeout is off
                  end
               end
               tsa_pkg::OP_TICK: begin
                  if (run_ff[i]) begin
                     count_in[i] = count_dec;
                     if (count_dec == '0) begin
                        run_in[i]   = 1'b0;
                        valid_in[i] = 1'b0;
                     end
                  end
               end
               default: ;
            endcase
         end
      end

      // alarms follow the post-update table and the current csr values
      master_in = 1'b0;
      for (int i = 0; i < NUM_TIRES; i++) begin
         nominal     = (i < 2) ? normal_front_ff : normal_rear_ff;
         caution[i]  = (ident_in[i] != '0) &&
                       (tsa_pkg::band_alarm(pres_in[i], nominal, caution_dev_ff) ||
                        tsa_pkg::temp_alarm(temp_in[i], temp_caution_ff));
         critical[i] = (ident_in[i] != '0) &&
                       (tsa_pkg::band_alarm(pres_in[i], nominal, critical_dev_ff) ||
                        tsa_pkg::temp_alarm(temp_in[i], temp_critical_ff));
         master_in   = master_in || (valid_in[i] && critical[i]);
      end

      // status and get readback
      status_in     = tsa_pkg::STATUS_OK;
      data_valid_in = 1'b0;
      tire_alarm_in = 1'b0;
      pres_out_in   = '0;
      temp_out_in   = '0;
      case (in_op_ff)
         tsa_pkg::OP_REGISTER: begin
            if (id_zero || !slot_ok) begin
               status_in = tsa_pkg::STATUS_INVALID;
            end else if (id_hit) begin
               status_in = tsa_pkg::STATUS_NOT_ALLOWED;
            end
         end
         tsa_pkg::OP_UNREGISTER: begin
            if (id_zero) begin
               status_in = tsa_pkg::STATUS_INVALID;
            end else if (!id_hit) begin
               status_in = tsa_pkg::STATUS_NOT_ALLOWED;
            end
         end
         tsa_pkg::OP_UPDATE: begin
            if (id_zero) begin
               status_in = tsa_pkg::STATUS_INVALID;
            end
         end
         tsa_pkg::OP_GET: begin
            if (!slot_ok) begin
               status_in = tsa_pkg::STATUS_INVALID;
            end
            for (int i = 0; i < NUM_TIRES; i++) begin
               if (slot_sel[i]) begin
                  if (ident_in[i] == '0) begin
                     status_in = tsa_pkg::STATUS_NOT_ALLOWED;
                  end else if (valid_in[i]) begin
                     data_valid_in = 1'b1;
                     tire_alarm_in = caution[i] || critical[i];
                     pres_out_in   = pres_in[i];
                     temp_out_in   = temp_in[i];
                  end
               end
            end
         end
         tsa_pkg::OP_TICK: ;
         default: status_in = tsa_pkg::STATUS_INVALID;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIRES; i++) begin
            ident_ff[i] <= '0;
            pres_ff[i]  <= '0;
            temp_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         valid_ff <= '0;
         run_ff   <= '0;
      end else begin
         for (int i = 0; i < NUM_TIRES; i++) begin
            ident_ff[i] <= ident_in[i];
            pres_ff[i]  <= pres_in[i];
            temp_ff[i]  <= temp_in[i];
            count_ff[i] <= count_in[i];
         end
         valid_ff <= valid_in;
         run_ff   <= run_in;
      end
   end

   // ---------------- response register ----------------
   logic                    rsp_valid_ff;
   tsa_pkg::status_type     rsp_status_ff;
   logic                    rsp_data_valid_ff, rsp_tire_alarm_ff, rsp_crit_any_ff;
   logic [PresW-1:0]        rsp_pres_ff;
   logic signed [TempW-1:0] rsp_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         rsp_status_ff     <= status_in;
         rsp_data_valid_ff <= data_valid_in;
         rsp_tire_alarm_ff <= tire_alarm_in;
         rsp_pres_ff       <= pres_out_in;
         rsp_temp_ff       <= temp_out_in;
         rsp_crit_any_ff   <= master_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_data_valid      = rsp_data_valid_ff;
   assign rsp_tire_alarm      = rsp_tire_alarm_ff;
   assign rsp_pressure_out    = rsp_pres_ff;
   assign rsp_temperature_out = rsp_temp_ff;
   assign rsp_critical_any    = rsp_crit_any_ff;

endmodule

// File: hw/rtl/tsa_checker.sv
// ----------------------------------------------------------------------------
// Tire sensor alarm table port checker
// Watches the request/response ports for latency and response consistency.
// ----------------------------------------------------------------------------
`include "tire_sensor_alarm_table_assert.svh"

module tsa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               rsp_valid,
   input logic [1:0]                         rsp_status,
   input logic                               rsp_data_valid,
   input logic                               rsp_tire_alarm,
   input logic [tsa_pkg::PresW-1:0]          rsp_pressure_out,
   input logic signed [tsa_pkg::TempW-1:0]   rsp_temperature_out
);

   logic req_accept;
   logic status_legal;
   logic readback_zero;

   assign req_accept    = start && !busy;
   assign status_legal  = (rsp_status == tsa_pkg::STATUS_OK) ||
                          (rsp_status == tsa_pkg::STATUS_INVALID) ||
                          (rsp_status == tsa_pkg::STATUS_NOT_ALLOWED);
   assign readback_zero = !rsp_tire_alarm && (rsp_pressure_out == '0) &&
                          (rsp_temperature_out == '0);

   // every accepted word is answered by a response word
   `TSA_ASSERT_IMP(a_rsp_follows_req, clock, reset, req_accept, ##2 rsp_valid, "no response word")

   // no response word without an earlier accepted request
   `TSA_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(req_accept, 2), "stray response")

   `TSA_ASSERT_IMP(a_status_legal, clock, reset, rsp_valid, status_legal, "illegal status code")

   // readback fields are zero unless valid data came back, and only with ok status
   `TSA_ASSERT_IMP(a_readback_clean, clock, reset, rsp_valid && !rsp_data_valid, readback_zero, "dirty readback")

   `TSA_ASSERT_IMP(a_readback_ok, clock, reset, rsp_valid && rsp_data_valid, status_legal && (rsp_status == tsa_pkg::STATUS_OK), "data with error")

endmodule

bind tire_sensor_alarm_table tsa_checker u_tsa_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Tire sensor alarm table testbench
// Drives request words through the command port and checks every response
// word against a shadow copy of the slot table, its timers and alarms, or a
// fixed expectation. A directed table covers reset state, field extremes and
// error codes. Seven register settings, the extremes among them, are then each
// followed by random words built mostly from a small pool of sensor ids.
// ----------------------------------------------------------------------------
module testbench;

   localparam int NUM_TIRES = 4;
   localparam int OpW      = tsa_pkg::OpW;
   localparam int IdentW   = tsa_pkg::IdentW;
   localparam int SlotW    = tsa_pkg::SlotW;
   localparam int PresW    = tsa_pkg::PresW;
   localparam int TempW    = tsa_pkg::TempW;
   localparam int TicksW   = tsa_pkg::TicksW;
   localparam int CsrAddrW = tsa_pkg::CsrAddrW;
   localparam int CsrDataW = tsa_pkg::CsrDataW;
   localparam logic [OpW-1:0] OpUnknown = 3'd5;

   typedef struct packed {
      logic [OpW-1:0]    op;
      logic [IdentW-1:0] ident;
      logic [SlotW-1:0]  slot;
      logic [PresW-1:0]  pres;
      logic [TempW-1:0]  temp;
   } word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             data_valid;
      logic             tire_alarm;
      logic [PresW-1:0] pressure;
      logic [TempW-1:0] temperature;
      logic             any_crit;
   } result_type;

   typedef struct packed {
      word_type   w;
      logic       fixed;
      result_type want;
   } row_type;

   localparam result_type NoWant = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [OpW-1:0]           req_op = '0;
   logic [IdentW-1:0]        req_sensor_ident = '0;
   logic [SlotW-1:0]         req_slot = '0;
   logic [PresW-1:0]         req_pressure_in = '0;
   logic signed [TempW-1:0]  req_temperature_in = '0;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic                     rsp_data_valid;
   logic                     rsp_tire_alarm;
   logic [PresW-1:0]         rsp_pressure_out;
   logic signed [TempW-1:0]  rsp_temperature_out;
   logic                     rsp_critical_any;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CsrAddrW-1:0]      paddr = '0;
   logic [CsrDataW-1:0]      pwdata = '0;
   logic [CsrDataW-1:0]      prdata;
   logic                     pready;

   always #6 clock = ~clock;

   tire_sensor_alarm_table #(.NUM_TIRES(NUM_TIRES)) u_dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_op(req_op), .req_sensor_ident(req_sensor_ident), .req_slot(req_slot),
      .req_pressure_in(req_pressure_in), .req_temperature_in(req_temperature_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data_valid(rsp_data_valid),
      .rsp_tire_alarm(rsp_tire_alarm), .rsp_pressure_out(rsp_pressure_out),
      .rsp_temperature_out(rsp_temperature_out), .rsp_critical_any(rsp_critical_any),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // shadow copy of the csr file
   logic [PresW-1:0]  cfg_front = tsa_pkg::NormalFrontReset;
   logic [PresW-1:0]  cfg_rear = tsa_pkg::NormalRearReset;
   logic [PresW-1:0]  cfg_caution_dev = tsa_pkg::CautionDevReset;
   logic [PresW-1:0]  cfg_critical_dev = tsa_pkg::CriticalDevReset;
   logic [TempW-1:0]  cfg_temp_caution = tsa_pkg::TempLimitReset;
   logic [TempW-1:0]  cfg_temp_critical = tsa_pkg::TempLimitReset;
   logic [TicksW-1:0] cfg_valid_ticks = tsa_pkg::ValidTicksReset;

   // shadow copy of the slot table
   logic [IdentW-1:0] tbl_ident [NUM_TIRES];
   logic [PresW-1:0]  tbl_pres [NUM_TIRES];
   logic [TempW-1:0]  tbl_temp [NUM_TIRES];
   logic              tbl_valid [NUM_TIRES];
   logic              tbl_running [NUM_TIRES];
   logic [TicksW-1:0] tbl_count [NUM_TIRES];

   result_type        expected_rsp [$];
   logic [IdentW-1:0] ident_pool [6];
   int                gap_style = 1;
   int                mismatches = 0;
   int                words_sent = 0;
   int                responses_checked = 0;
   int                settings_used = 0;
   int                expiries = 0;
   int                crit_words = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s at response %0d: got %0h, expected %0h",
               what, responses_checked, got, want);
      mismatches++;
   endtask

   function automatic int find_slot(input logic [IdentW-1:0] ident);
      for (int i = 0; i < NUM_TIRES; i++)
         if (tbl_ident[i] == ident) return i;
      return -1;
   endfunction

   // {critical, caution}; slots 0 and 1 use the front nominal
   function automatic logic [1:0] slot_alarms(input int i);
      int nom, p, t, tcl, tkl;
      logic caution, critical;
      nom = (i < 2) ? int'(cfg_front) : int'(cfg_rear);
      p = int'(tbl_pres[i]);
      t = int'($signed(tbl_temp[i]));
      tcl = int'($signed(cfg_temp_caution));
      tkl = int'($signed(cfg_temp_critical));
      caution = p < nom - int'(cfg_caution_dev) || p > nom + int'(cfg_caution_dev)
                || (tcl > 0 && t > tcl);
      critical = p < nom - int'(cfg_critical_dev) || p > nom + int'(cfg_critical_dev)
                 || (tkl > 0 && t > tkl);
      return {critical, caution};
   endfunction

   function automatic void vacate(input int s);
      tbl_valid[s] = 1'b0;
      tbl_running[s] = 1'b0;
      tbl_count[s] = '0;
   endfunction

   task automatic predict_word(input word_type w, output result_type r);
      int s;
      logic [1:0] al;
      r = '0;
      case (w.op)
         tsa_pkg::OP_REGISTER: begin
            if (w.ident == 0 || w.slot >= NUM_TIRES) r.status = tsa_pkg::STATUS_INVALID;
            else if (find_slot(w.ident) >= 0) r.status = tsa_pkg::STATUS_NOT_ALLOWED;
            else begin
               tbl_ident[w.slot] = w.ident;
               vacate(w.slot);
            end
         end
         tsa_pkg::OP_UNREGISTER: begin
            s = find_slot(w.ident);
            if (w.ident == 0) r.status = tsa_pkg::STATUS_INVALID;
            else if (s < 0) r.status = tsa_pkg::STATUS_NOT_ALLOWED;
            else begin
               tbl_ident[s] = '0;
               vacate(s);
            end
         end
         tsa_pkg::OP_UPDATE: begin
            s = find_slot(w.ident);
            if (w.ident == 0) r.status = tsa_pkg::STATUS_INVALID;
            else if (s >= 0) begin   // unknown id: ok, nothing stored
               tbl_pres[s] = w.pres;
               tbl_temp[s] = w.temp;
               tbl_valid[s] = 1'b1;
               tbl_running[s] = (cfg_valid_ticks != 0);
               tbl_count[s] = cfg_valid_ticks;
            end
         end
         tsa_pkg::OP_GET: ;
         tsa_pkg::OP_TICK: begin
            for (int i = 0; i < NUM_TIRES; i++) begin
               if (tbl_running[i]) begin
                  tbl_count[i] = tbl_count[i] - 1;
                  if (tbl_count[i] == 0) begin
                     tbl_running[i] = 1'b0;
                     tbl_valid[i] = 1'b0;
                     expiries++;
                  end
               end
            end
         end
         default: r.status = tsa_pkg::STATUS_INVALID;
      endcase
      for (int i = 0; i < NUM_TIRES; i++) begin
         al = slot_alarms(i);
         if (tbl_valid[i] && al[1]) r.any_crit = 1'b1;
      end
      if (w.op == tsa_pkg::OP_GET) begin
         if (w.slot >= NUM_TIRES) r.status = tsa_pkg::STATUS_INVALID;
         else if (tbl_ident[w.slot] == 0) r.status = tsa_pkg::STATUS_NOT_ALLOWED;
         else if (tbl_valid[w.slot]) begin
            al = slot_alarms(w.slot);
            r.data_valid = 1'b1;
            r.tire_alarm = |al;
            r.pressure = tbl_pres[w.slot];
            r.temperature = tbl_temp[w.slot];
         end
      end
      if (r.any_crit) crit_words++;
   endtask

   function automatic int draw_gap();
      if ($urandom_range(0, 29) == 0) gap_style = $urandom_range(0, 2);
      case (gap_style)
         0: return 0;
         1: return $urandom_range(0, 18);
         default: return $urandom_range(0, 2);
      endcase
   endfunction

   // waits out the gap, holds the word until taken, then books its response
   task automatic issue_word(input row_type r);
      int gap;
      result_type want;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= r.w.op;
      req_sensor_ident <= r.w.ident;
      req_slot <= r.w.slot;
      req_pressure_in <= r.w.pres;
      req_temperature_in <= r.w.temp;
      do @(posedge clock); while (busy !== 1'b0);
      predict_word(r.w, want);
      if (r.fixed) want = r.want;
      expected_rsp.push_back(want);
      words_sent++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // leaves psel high so back-to-back writes need no extra step
   task automatic csr_write(input tsa_pkg::csr_index_type idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (idx)
         tsa_pkg::CSR_NORMAL_FRONT:  cfg_front = value[PresW-1:0];
         tsa_pkg::CSR_NORMAL_REAR:   cfg_rear = value[PresW-1:0];
         tsa_pkg::CSR_CAUTION_DEV:   cfg_caution_dev = value[PresW-1:0];
         tsa_pkg::CSR_CRITICAL_DEV:  cfg_critical_dev = value[PresW-1:0];
         tsa_pkg::CSR_TEMP_CAUTION:  cfg_temp_caution = value[TempW-1:0];
         tsa_pkg::CSR_TEMP_CRITICAL: cfg_temp_critical = value[TempW-1:0];
         tsa_pkg::CSR_VALID_TICKS:   cfg_valid_ticks = value;
         default: ;
      endcase
   endtask

   task automatic program_table(input int front, input int rear, input int cdev,
                                input int kdev, input int tcl, input int tkl,
                                input logic [31:0] ticks);
      csr_write(tsa_pkg::CSR_NORMAL_FRONT, front);
      csr_write(tsa_pkg::CSR_NORMAL_REAR, rear);
      csr_write(tsa_pkg::CSR_CAUTION_DEV, cdev);
      csr_write(tsa_pkg::CSR_CRITICAL_DEV, kdev);
      csr_write(tsa_pkg::CSR_TEMP_CAUTION, tcl);
      csr_write(tsa_pkg::CSR_TEMP_CRITICAL, tkl);
      csr_write(tsa_pkg::CSR_VALID_TICKS, ticks);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function automatic row_type row(input logic [OpW-1:0] op, input logic [IdentW-1:0] ident,
                                   input int slot, input int pres, input int temp,
                                   input logic fixed, input result_type want);
      row_type r;
      r.w.op = op;
      r.w.ident = ident;
      r.w.slot = slot[SlotW-1:0];
      r.w.pres = pres[PresW-1:0];
      r.w.temp = temp[TempW-1:0];
      r.fixed = fixed;
      r.want = want;
      return r;
   endfunction

   function automatic logic [IdentW-1:0] pick_ident();
      if ($urandom_range(0, 24) == 0) return '0;
      return ident_pool[$urandom_range(0, 5)];
   endfunction

   // mostly ids from the pool with pressure near the band edges
   function automatic row_type random_row();
      int pick, s, nom, span, p, t, lim;
      logic [OpW-1:0] op;
      logic [IdentW-1:0] ident;
      pick = $urandom_range(0, 99);
      if (pick < 12) op = tsa_pkg::OP_REGISTER;
      else if (pick < 20) op = tsa_pkg::OP_UNREGISTER;
      else if (pick < 52) op = tsa_pkg::OP_UPDATE;
      else if (pick < 75) op = tsa_pkg::OP_GET;
      else if (pick < 96) op = tsa_pkg::OP_TICK;
      else op = OpW'($urandom_range(5, 7));
      ident = pick_ident();
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3);
      if (op == tsa_pkg::OP_UPDATE && find_slot(ident) >= 0) s = find_slot(ident);
      nom = (s < 2) ? int'(cfg_front) : int'(cfg_rear);
      span = int'(cfg_critical_dev) + 20;
      case ($urandom_range(0, 9))
         0: p = $urandom_range(0, 16383);
         1: p = $urandom_range(0, 1) ? 16383 : 0;
         default: p = nom - span + int'($urandom_range(0, 2 * span));
      endcase
      if (p < 0) p = 0;
      if (p > 16383) p = 16383;
      lim = $urandom_range(0, 1) ? int'($signed(cfg_temp_caution))
                                 : int'($signed(cfg_temp_critical));
      if ($urandom_range(0, 2) == 0) t = lim - 3 + int'($urandom_range(0, 6));
      else t = int'($urandom_range(0, 3000)) - 1000;
      if (t < -1000) t = -1000;
      if (t > 2000) t = 2000;
      if (op != tsa_pkg::OP_UPDATE && $urandom_range(0, 3) == 0) ident = $urandom();
      return row(op, ident, s, p, t, 1'b0, NoWant);
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("response word with nothing outstanding, status",
                            32'(rsp_status), 32'd0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_data_valid !== want.data_valid)
               report_mismatch("data_valid", 32'(rsp_data_valid), 32'(want.data_valid));
            if (rsp_tire_alarm !== want.tire_alarm)
               report_mismatch("tire_alarm", 32'(rsp_tire_alarm), 32'(want.tire_alarm));
            if (rsp_pressure_out !== want.pressure)
               report_mismatch("pressure_out", 32'(rsp_pressure_out), 32'(want.pressure));
            if ($unsigned(rsp_temperature_out) !== want.temperature)
               report_mismatch("temperature_out", 32'($unsigned(rsp_temperature_out)),
                               32'(want.temperature));
            if (rsp_critical_any !== want.any_crit)
               report_mismatch("critical_any", 32'(rsp_critical_any), 32'(want.any_crit));
         end
         responses_checked++;
      end
   end

   initial begin
      #2_000_000;
      $display("Timeout waiting for the request or response side");
      $display("Some tests failed");
      $finish;
   end

   initial begin
      row_type plan [$];
      int tcl, tkl;
      for (int i = 0; i < NUM_TIRES; i++) begin
         tbl_ident[i] = '0;
         tbl_pres[i] = '0;
         tbl_temp[i] = '0;
         tbl_valid[i] = 1'b0;
         tbl_running[i] = 1'b0;
         tbl_count[i] = '0;
      end
      foreach (ident_pool[k]) ident_pool[k] = $urandom();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: front/rear 2300, deviations 200/400, no temp limit, no timeout
      plan.push_back(row(tsa_pkg::OP_GET, 0, 0, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_NOT_ALLOWED, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_GET, 0, 7, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_INVALID, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_REGISTER, 0, 0, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_INVALID, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_REGISTER, 1, 4, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_INVALID, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_REGISTER, 32'hFFFF_FFFF, 0, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_OK, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      // duplicate id, in another slot and in its own slot
      plan.push_back(row(tsa_pkg::OP_REGISTER, 32'hFFFF_FFFF, 1, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_NOT_ALLOWED, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_REGISTER, 32'hFFFF_FFFF, 0, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_NOT_ALLOWED, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_REGISTER, 1, 1, 0, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_REGISTER, 2, 2, 0, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_REGISTER, 3, 3, 0, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_UPDATE, 0, 0, 100, 100, 1'b1,
         result_type'{tsa_pkg::STATUS_INVALID, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_UPDATE, 12345, 0, 100, 100, 1'b1,
         result_type'{tsa_pkg::STATUS_OK, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      // occupied, never updated
      plan.push_back(row(tsa_pkg::OP_GET, 0, 1, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_OK, 1'b0, 1'b0, 14'd0, 12'd0, 1'b0}));
      plan.push_back(row(tsa_pkg::OP_UPDATE, 32'hFFFF_FFFF, 0, 16383, 2000, 1'b1,
         result_type'{tsa_pkg::STATUS_OK, 1'b0, 1'b0, 14'd0, 12'd0, 1'b1}));
      plan.push_back(row(tsa_pkg::OP_GET, 0, 0, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_OK, 1'b1, 1'b1, 14'd16383, 12'd2000, 1'b1}));
      plan.push_back(row(tsa_pkg::OP_UPDATE, 1, 0, 0, -1000, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_UPDATE, 2, 0, 2300, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_GET, 0, 2, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_OK, 1'b1, 1'b0, 14'd2300, 12'd0, 1'b1}));
      // on the caution edge, then one below it
      plan.push_back(row(tsa_pkg::OP_UPDATE, 3, 0, 2100, 5, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_GET, 0, 3, 0, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_UPDATE, 3, 0, 2099, 5, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_GET, 0, 3, 0, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_TICK, 0, 0, 0, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_UNREGISTER, 0, 0, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_INVALID, 1'b0, 1'b0, 14'd0, 12'd0, 1'b1}));
      plan.push_back(row(tsa_pkg::OP_UNREGISTER, 77, 0, 0, 0, 1'b1,
         result_type'{tsa_pkg::STATUS_NOT_ALLOWED, 1'b0, 1'b0, 14'd0, 12'd0, 1'b1}));
      // new id replaces the one held in slot 1
      plan.push_back(row(tsa_pkg::OP_REGISTER, 9, 1, 0, 0, 1'b0, NoWant));
      plan.push_back(row(tsa_pkg::OP_UNREGISTER, 32'hFFFF_FFFF, 0, 0, 0, 1'b0, NoWant));
      plan.push_back(row(OpUnknown, 3, 2, 0, 0, 1'b0, NoWant));
      foreach (plan[k]) issue_word(plan[k]);

      for (int phase = 0; phase < 7; phase++) begin
         // hold off until every response word is back before touching the csrs
         wait_idle();
         case (phase)
            0: program_table(2300, 2300, 200, 400, 600, 900, 5);
            1: program_table(0, 0, 0, 0, -1000, 0, 1);
            2: program_table(16383, 16383, 16383, 16383, 2000, 2000, 32'hFFFF_FFFF);
            3: program_table(2200, 2500, 0, 150, 1, 2000, 0);
            default: begin
               tcl = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 3000)) - 1000
                                               : int'($urandom_range(300, 1200));
               tkl = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 3000)) - 1000
                                               : int'($urandom_range(600, 1600));
               program_table($urandom_range(1800, 2800), $urandom_range(1800, 2800),
                             $urandom_range(0, 500), $urandom_range(0, 900), tcl, tkl,
                             $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 12));
            end
         endcase
         ident_pool[0] = $urandom();
         ident_pool[1] = $urandom();
         ident_pool[5] = phase[0] ? 32'hFFFF_FFFF : 32'h1;
         repeat (70) issue_word(random_row());
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("response words still outstanding", 32'(expected_rsp.size()),
                         32'd0);
      $display("Ran %0d request words over %0d csr settings, %0d response words checked.",
               words_sent, settings_used, responses_checked);
      $display("Timer expiries seen: %0d, words with a critical slot flagged: %0d.",
               expiries, crit_words);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/tsa_pkg.sv
hw/rtl/tire_sensor_alarm_table.sv
hw/rtl/tsa_checker.sv
tb/testbench.sv
